// ===== rtl/lvc_pkg.sv =====
// shared types, constants and the microcode table of the lat/lon vertex unit
// no dependencies; every other file refers to this package by scoped names
package lvc_pkg;

    localparam int unsigned MAX_POINTS = 65536;

    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int COORD_W = 25;
    localparam int RAD_W   = 24;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 2;
    localparam int STEP_W  = 6;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 96;

    typedef logic signed [31:0] word_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam word_t Q30_ONE       = 32'sh4000_0000;
    localparam word_t RAD_PER_DEG   = 32'sd18740330;
    localparam word_t FLAT_HALF_DIV = 32'sd90;
    localparam longint COORD_LIM    = 64'sd16777215;
    localparam word_t FLAT_Z        = -32'sd131;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd65536;

    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_MODE   = 2'd1;

    // reciprocals rounded up, Q32
    localparam longint unsigned TWO32 = 64'd4294967296;
    localparam word_t RECIP_6   = word_t'((TWO32 + 64'd5) / 64'd6);
    localparam word_t RECIP_12  = word_t'((TWO32 + 64'd11) / 64'd12);
    localparam word_t RECIP_20  = word_t'((TWO32 + 64'd19) / 64'd20);
    localparam word_t RECIP_30  = word_t'((TWO32 + 64'd29) / 64'd30);
    localparam word_t RECIP_42  = word_t'((TWO32 + 64'd41) / 64'd42);
    localparam word_t RECIP_56  = word_t'((TWO32 + 64'd55) / 64'd56);
    localparam word_t RECIP_180 = word_t'((TWO32 + 64'd179) / 64'd180);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        SRC_D0, SRC_D1, SRC_K,
        SRC_T0, SRC_T1, SRC_T2_0, SRC_T2_1,
        SRC_S0, SRC_S1, SRC_C0, SRC_C1,
        SRC_SIN0, SRC_SIN1, SRC_COS0, SRC_COS1,
        SRC_PX, SRC_PY, SRC_RAD, SRC_RECIP,
        SRC_ABS_LAT, SRC_ABS_LON
    } src_t;

    typedef enum logic [3:0] {
        DST_T0, DST_T1, DST_T2_0, DST_T2_1,
        DST_S0, DST_S1, DST_C0, DST_C1,
        DST_PX, DST_PY, DST_X, DST_Y, DST_Z
    } dst_t;

    typedef enum logic [2:0] {
        PST_RND16,      // round half away, shift 16
        PST_RND30,      // round half away, shift 30
        PST_DIV_ONE,    // one minus quotient
        PST_HALF_ONE,   // one minus rounded product halved
        PST_SAT30,      // round, shift 30, clamp to coordinate range
        PST_DIV_SIGN,   // quotient with sign restored
        PST_FLAT_Z
    } post_t;

    typedef enum logic [2:0] {
        DV_NONE, DV_6, DV_12, DV_20, DV_30, DV_42, DV_56, DV_180
    } dvs_t;

    typedef struct packed {
        src_t  a;
        src_t  b;
        post_t post;
        dvs_t  dv;
        dst_t  dst;
        logic  last;
    } uop_t;

    typedef struct packed {
        logic  reduce;
        logic  issue;
        uop_t  uop;
    } seq_ctl_t;

    typedef struct packed {
        logic  valid;
        word_t a;
        word_t b;
        logic  neg;
        post_t post;
        dvs_t  dv;
        dst_t  dst;
    } issue_t;

    typedef struct packed {
        logic  valid;
        dst_t  dst;
        word_t value;
    } wb_t;

    localparam logic [STEP_W-1:0] SPHERE_START = 6'd0;
    localparam logic [STEP_W-1:0] FLAT_START   = 6'd33;

    function automatic word_t div_recip(input dvs_t dv);
        word_t r;
        case (dv)
            DV_6:    r = RECIP_6;
            DV_12:   r = RECIP_12;
            DV_20:   r = RECIP_20;
            DV_30:   r = RECIP_30;
            DV_42:   r = RECIP_42;
            DV_56:   r = RECIP_56;
            DV_180:  r = RECIP_180;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] div_const(input dvs_t dv);
        logic [7:0] k;
        case (dv)
            DV_6:    k = 8'd6;
            DV_12:   k = 8'd12;
            DV_20:   k = 8'd20;
            DV_30:   k = 8'd30;
            DV_42:   k = 8'd42;
            DV_56:   k = 8'd56;
            DV_180:  k = 8'd180;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    function automatic uop_t mk(input src_t a, input src_t b, input post_t post,
                                input dvs_t dv, input dst_t dst, input logic last);
        uop_t u;
        u.a    = a;
        u.b    = b;
        u.post = post;
        u.dv   = dv;
        u.dst  = dst;
        u.last = last;
        return u;
    endfunction

    // lat and lon ops alternate so each result is written back before its next use
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            6'd0:  u = mk(SRC_D0,    SRC_K,     PST_RND16,    DV_NONE, DST_T0,   1'b0);
            6'd1:  u = mk(SRC_D1,    SRC_K,     PST_RND16,    DV_NONE, DST_T1,   1'b0);
            6'd2:  u = mk(SRC_T0,    SRC_T0,    PST_RND30,    DV_NONE, DST_T2_0, 1'b0);
            6'd3:  u = mk(SRC_T1,    SRC_T1,    PST_RND30,    DV_NONE, DST_T2_1, 1'b0);
            // cosine series
            6'd4:  u = mk(SRC_T2_0,  SRC_RECIP, PST_DIV_ONE,  DV_56,   DST_C0,   1'b0);
            6'd5:  u = mk(SRC_T2_1,  SRC_RECIP, PST_DIV_ONE,  DV_56,   DST_C1,   1'b0);
            6'd6:  u = mk(SRC_T2_0,  SRC_C0,    PST_RND30,    DV_NONE, DST_C0,   1'b0);
            6'd7:  u = mk(SRC_T2_1,  SRC_C1,    PST_RND30,    DV_NONE, DST_C1,   1'b0);
            6'd8:  u = mk(SRC_C0,    SRC_RECIP, PST_DIV_ONE,  DV_30,   DST_C0,   1'b0);
            6'd9:  u = mk(SRC_C1,    SRC_RECIP, PST_DIV_ONE,  DV_30,   DST_C1,   1'b0);
            6'd10: u = mk(SRC_T2_0,  SRC_C0,    PST_RND30,    DV_NONE, DST_C0,   1'b0);
            6'd11: u = mk(SRC_T2_1,  SRC_C1,    PST_RND30,    DV_NONE, DST_C1,   1'b0);
            6'd12: u = mk(SRC_C0,    SRC_RECIP, PST_DIV_ONE,  DV_12,   DST_C0,   1'b0);
            6'd13: u = mk(SRC_C1,    SRC_RECIP, PST_DIV_ONE,  DV_12,   DST_C1,   1'b0);
            6'd14: u = mk(SRC_T2_0,  SRC_C0,    PST_HALF_ONE, DV_NONE, DST_C0,   1'b0);
            6'd15: u = mk(SRC_T2_1,  SRC_C1,    PST_HALF_ONE, DV_NONE, DST_C1,   1'b0);
            // sine series
            6'd16: u = mk(SRC_T2_0,  SRC_RECIP, PST_DIV_ONE,  DV_42,   DST_S0,   1'b0);
            6'd17: u = mk(SRC_T2_1,  SRC_RECIP, PST_DIV_ONE,  DV_42,   DST_S1,   1'b0);
            6'd18: u = mk(SRC_T2_0,  SRC_S0,    PST_RND30,    DV_NONE, DST_S0,   1'b0);
            6'd19: u = mk(SRC_T2_1,  SRC_S1,    PST_RND30,    DV_NONE, DST_S1,   1'b0);
            6'd20: u = mk(SRC_S0,    SRC_RECIP, PST_DIV_ONE,  DV_20,   DST_S0,   1'b0);
            6'd21: u = mk(SRC_S1,    SRC_RECIP, PST_DIV_ONE,  DV_20,   DST_S1,   1'b0);
            6'd22: u = mk(SRC_T2_0,  SRC_S0,    PST_RND30,    DV_NONE, DST_S0,   1'b0);
            6'd23: u = mk(SRC_T2_1,  SRC_S1,    PST_RND30,    DV_NONE, DST_S1,   1'b0);
            6'd24: u = mk(SRC_S0,    SRC_RECIP, PST_DIV_ONE,  DV_6,    DST_S0,   1'b0);
            6'd25: u = mk(SRC_S1,    SRC_RECIP, PST_DIV_ONE,  DV_6,    DST_S1,   1'b0);
            6'd26: u = mk(SRC_T0,    SRC_S0,    PST_RND30,    DV_NONE, DST_S0,   1'b0);
            6'd27: u = mk(SRC_T1,    SRC_S1,    PST_RND30,    DV_NONE, DST_S1,   1'b0);
            // vertex: z first, as the lon sine lands after the lat sine
            6'd28: u = mk(SRC_SIN0,  SRC_RAD,   PST_SAT30,    DV_NONE, DST_Z,    1'b0);
            6'd29: u = mk(SRC_COS0,  SRC_COS1,  PST_RND30,    DV_NONE, DST_PX,   1'b0);
            6'd30: u = mk(SRC_COS0,  SRC_SIN1,  PST_RND30,    DV_NONE, DST_PY,   1'b0);
            6'd31: u = mk(SRC_PX,    SRC_RAD,   PST_SAT30,    DV_NONE, DST_X,    1'b0);
            6'd32: u = mk(SRC_PY,    SRC_RAD,   PST_SAT30,    DV_NONE, DST_Y,    1'b1);
            // flat projection
            6'd33: u = mk(SRC_ABS_LAT, SRC_RECIP, PST_DIV_SIGN, DV_180, DST_X,  1'b0);
            6'd34: u = mk(SRC_ABS_LON, SRC_RECIP, PST_DIV_SIGN, DV_180, DST_Y,  1'b0);
            6'd35: u = mk(SRC_RAD,   SRC_RAD,   PST_FLAT_Z,   DV_NONE, DST_Z,    1'b1);
            default: u = mk(SRC_RAD, SRC_RAD,   PST_FLAT_Z,   DV_NONE, DST_Z,    1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/lvc_mul_unit.sv =====
// shared 32x32 signed multiplier with registered product and result post-processing
// (rounding shifts, signed reciprocal division with correction, saturation, flat z); uses lvc_pkg
module lvc_mul_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  lvc_pkg::issue_t  iss,
    output lvc_pkg::wb_t     wb
);

    localparam longint H16 = 64'sd32768;
    localparam longint H30 = 64'sd536870912;

    logic signed [63:0] prod_reg;
    lvc_pkg::word_t     opa_reg;
    logic               neg_reg;
    lvc_pkg::post_t     post_reg;
    lvc_pkg::dvs_t      dv_reg;
    lvc_pkg::dst_t      dst_reg;
    logic               vld_reg;

    logic signed [63:0] r16;
    logic signed [63:0] r30;
    logic [31:0]        qe;
    logic [39:0]        qk;
    logic [31:0]        qc;
    lvc_pkg::word_t     value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= iss.valid;
        end
        if (iss.valid) begin
            prod_reg <= 64'(iss.a) * 64'(iss.b);
            opa_reg  <= iss.a;
            neg_reg  <= iss.neg;
            post_reg <= iss.post;
            dv_reg   <= iss.dv;
            dst_reg  <= iss.dst;
        end
    end

    always_comb begin
        // round half away from zero
        if (prod_reg[63]) begin
            r16 = -((-prod_reg + H16) >>> 16);
            r30 = -((-prod_reg + H30) >>> 30);
        end else begin
            r16 = (prod_reg + H16) >>> 16;
            r30 = (prod_reg + H30) >>> 30;
        end
        // reciprocal estimate is exact or one high
        qe = prod_reg[63:32];
        qk = 40'(qe) * 40'(lvc_pkg::div_const(dv_reg));
        qc = (qk > 40'($unsigned(opa_reg))) ? qe - 32'd1 : qe;
    end

    always_comb begin
        case (post_reg)
            lvc_pkg::PST_RND16:    value = 32'(r16);
            lvc_pkg::PST_RND30:    value = 32'(r30);
            lvc_pkg::PST_DIV_ONE:  value = lvc_pkg::Q30_ONE - $signed(qc);
            lvc_pkg::PST_HALF_ONE: value = lvc_pkg::Q30_ONE - 32'(r30 >>> 1);
            lvc_pkg::PST_SAT30: begin
                if (r30 > lvc_pkg::COORD_LIM) begin
                    value = 32'(lvc_pkg::COORD_LIM);
                end else if (r30 < -lvc_pkg::COORD_LIM) begin
                    value = 32'(-lvc_pkg::COORD_LIM);
                end else begin
                    value = 32'(r30);
                end
            end
            lvc_pkg::PST_DIV_SIGN: value = neg_reg ? -$signed(qc) : $signed(qc);
            lvc_pkg::PST_FLAT_Z:   value = lvc_pkg::FLAT_Z;
            default:               value = '0;
        endcase
    end

    assign wb.valid = vld_reg;
    assign wb.dst   = dst_reg;
    assign wb.value = value;

endmodule

// ===== rtl/lvc_regfile.sv =====
// working registers: angle reduction, quadrant mapping, operand select for the
// shared multiplier and result writeback; uses lvc_pkg
module lvc_regfile (
    input  logic                            aclk,
    input  logic signed [lvc_pkg::LAT_W-1:0] lat,
    input  logic signed [lvc_pkg::LON_W-1:0] lon,
    input  logic [lvc_pkg::RAD_W-1:0]        radius,
    input  lvc_pkg::seq_ctl_t                ctl,
    input  lvc_pkg::wb_t                     wb,
    output lvc_pkg::issue_t                  iss,
    output lvc_pkg::coord_t                  coord_x,
    output lvc_pkg::coord_t                  coord_y,
    output lvc_pkg::coord_t                  coord_z
);

    localparam logic signed [25:0] DEG45  = 26'sd2949120;
    localparam logic signed [25:0] DEG90  = 26'sd5898240;
    localparam logic signed [25:0] DEG135 = 26'sd8847360;
    localparam logic signed [25:0] DEG180 = 26'sd11796480;
    localparam logic signed [25:0] DEG225 = 26'sd14745600;
    localparam logic signed [25:0] DEG270 = 26'sd17694720;
    localparam logic signed [25:0] DEG315 = 26'sd20643840;
    localparam logic signed [25:0] DEG360 = 26'sd23592960;

    typedef struct packed {
        lvc_pkg::word_t d;
        logic [1:0]     q;
    } red_t;

    // wrap to [0,360) and split into quadrant and residual in [-45,45)
    function automatic red_t reduce(input logic signed [25:0] a);
        logic signed [25:0] r;
        logic signed [25:0] base;
        red_t               o;
        r = (a < 0) ? a + DEG360 : a;
        if (r < DEG45) begin
            base = '0;
            o.q  = 2'd0;
        end else if (r < DEG135) begin
            base = DEG90;
            o.q  = 2'd1;
        end else if (r < DEG225) begin
            base = DEG180;
            o.q  = 2'd2;
        end else if (r < DEG315) begin
            base = DEG270;
            o.q  = 2'd3;
        end else begin
            base = DEG360;
            o.q  = 2'd0;
        end
        o.d = 32'(r - base);
        return o;
    endfunction

    lvc_pkg::word_t d0_reg, d1_reg;
    logic [1:0]     q0_reg, q1_reg;
    lvc_pkg::word_t t0_reg, t1_reg, t2_0_reg, t2_1_reg;
    lvc_pkg::word_t s0_reg, s1_reg, c0_reg, c1_reg;
    lvc_pkg::word_t px_reg, py_reg;
    lvc_pkg::coord_t x_reg, y_reg, z_reg;

    red_t           red_lat, red_lon;
    lvc_pkg::word_t sin0, cos0, sin1, cos1;
    lvc_pkg::word_t lat_w, lon_w, abs_lat, abs_lon;

    always_comb begin
        red_lat = reduce(26'(lat));
        red_lon = reduce(26'(lon));
        lat_w   = 32'(lat);
        lon_w   = 32'(lon);
        abs_lat = ((lat_w < 0) ? -lat_w : lat_w) + lvc_pkg::FLAT_HALF_DIV;
        abs_lon = ((lon_w < 0) ? -lon_w : lon_w) + lvc_pkg::FLAT_HALF_DIV;
    end

    always_comb begin
        case (q0_reg)
            2'd0:    begin sin0 = s0_reg;  cos0 = c0_reg;  end
            2'd1:    begin sin0 = c0_reg;  cos0 = -s0_reg; end
            2'd2:    begin sin0 = -s0_reg; cos0 = -c0_reg; end
            default: begin sin0 = -c0_reg; cos0 = s0_reg;  end
        endcase
        case (q1_reg)
            2'd0:    begin sin1 = s1_reg;  cos1 = c1_reg;  end
            2'd1:    begin sin1 = c1_reg;  cos1 = -s1_reg; end
            2'd2:    begin sin1 = -s1_reg; cos1 = -c1_reg; end
            default: begin sin1 = -c1_reg; cos1 = s1_reg;  end
        endcase
    end

    function automatic lvc_pkg::word_t operand(input lvc_pkg::src_t s);
        lvc_pkg::word_t v;
        case (s)
            lvc_pkg::SRC_D0:      v = d0_reg;
            lvc_pkg::SRC_D1:      v = d1_reg;
            lvc_pkg::SRC_K:       v = lvc_pkg::RAD_PER_DEG;
            lvc_pkg::SRC_T0:      v = t0_reg;
            lvc_pkg::SRC_T1:      v = t1_reg;
            lvc_pkg::SRC_T2_0:    v = t2_0_reg;
            lvc_pkg::SRC_T2_1:    v = t2_1_reg;
            lvc_pkg::SRC_S0:      v = s0_reg;
            lvc_pkg::SRC_S1:      v = s1_reg;
            lvc_pkg::SRC_C0:      v = c0_reg;
            lvc_pkg::SRC_C1:      v = c1_reg;
            lvc_pkg::SRC_SIN0:    v = sin0;
            lvc_pkg::SRC_SIN1:    v = sin1;
            lvc_pkg::SRC_COS0:    v = cos0;
            lvc_pkg::SRC_COS1:    v = cos1;
            lvc_pkg::SRC_PX:      v = px_reg;
            lvc_pkg::SRC_PY:      v = py_reg;
            lvc_pkg::SRC_RAD:     v = $signed(32'(radius));
            lvc_pkg::SRC_RECIP:   v = lvc_pkg::div_recip(ctl.uop.dv);
            lvc_pkg::SRC_ABS_LAT: v = abs_lat;
            lvc_pkg::SRC_ABS_LON: v = abs_lon;
            default:              v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        iss.valid = ctl.issue;
        iss.a     = operand(ctl.uop.a);
        iss.b     = operand(ctl.uop.b);
        iss.neg   = ((ctl.uop.a == lvc_pkg::SRC_ABS_LAT) && (lat < 0)) ||
                    ((ctl.uop.a == lvc_pkg::SRC_ABS_LON) && (lon < 0));
        iss.post  = ctl.uop.post;
        iss.dv    = ctl.uop.dv;
        iss.dst   = ctl.uop.dst;
    end

    always_ff @(posedge aclk) begin
        if (ctl.reduce) begin
            d0_reg <= red_lat.d;
            q0_reg <= red_lat.q;
            d1_reg <= red_lon.d;
            q1_reg <= red_lon.q;
        end
        if (wb.valid) begin
            case (wb.dst)
                lvc_pkg::DST_T0:   t0_reg   <= wb.value;
                lvc_pkg::DST_T1:   t1_reg   <= wb.value;
                lvc_pkg::DST_T2_0: t2_0_reg <= wb.value;
                lvc_pkg::DST_T2_1: t2_1_reg <= wb.value;
                lvc_pkg::DST_S0:   s0_reg   <= wb.value;
                lvc_pkg::DST_S1:   s1_reg   <= wb.value;
                lvc_pkg::DST_C0:   c0_reg   <= wb.value;
                lvc_pkg::DST_C1:   c1_reg   <= wb.value;
                lvc_pkg::DST_PX:   px_reg   <= wb.value;
                lvc_pkg::DST_PY:   py_reg   <= wb.value;
                lvc_pkg::DST_X:    x_reg    <= lvc_pkg::COORD_W'(wb.value);
                lvc_pkg::DST_Y:    y_reg    <= lvc_pkg::COORD_W'(wb.value);
                lvc_pkg::DST_Z:    z_reg    <= lvc_pkg::COORD_W'(wb.value);
                default: ;
            endcase
        end
    end

    assign coord_x = x_reg;
    assign coord_y = y_reg;
    assign coord_z = z_reg;

endmodule

// ===== rtl/lvc_seq.sv =====
// sequencer: state machine and microcode step counter driving the shared multiplier
// uses lvc_pkg for the state type and the microcode table
module lvc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              mode,
    input  logic              out_free,
    output lvc_pkg::seq_ctl_t ctl,
    output logic              ready,
    output logic              load
);

    lvc_pkg::state_t state_reg, state_next;
    logic [lvc_pkg::STEP_W-1:0] step_reg, step_next;
    lvc_pkg::uop_t uop;

    assign uop = lvc_pkg::uop_at(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvc_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            lvc_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = lvc_pkg::ST_REDUCE;
                end
            end
            lvc_pkg::ST_REDUCE: begin
                step_next  = mode ? lvc_pkg::SPHERE_START : lvc_pkg::FLAT_START;
                state_next = lvc_pkg::ST_RUN;
            end
            lvc_pkg::ST_RUN: begin
                if (uop.last) begin
                    state_next = lvc_pkg::ST_DRAIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            lvc_pkg::ST_DRAIN: begin
                state_next = lvc_pkg::ST_DONE;
            end
            lvc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lvc_pkg::ST_IDLE;
                end
            end
            default: state_next = lvc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.reduce = (state_reg == lvc_pkg::ST_REDUCE);
        ctl.issue  = (state_reg == lvc_pkg::ST_RUN);
        ctl.uop    = uop;
        ready      = (state_reg == lvc_pkg::ST_IDLE);
        load       = (state_reg == lvc_pkg::ST_DONE) && out_free;
    end

endmodule

// ===== rtl/latlon_to_cartesian_vertex_unit.sv =====
// Lat/lon to vertex unit: stream in, stream out, config write port.
// Sphere mode: each result is computed by 33 dependent products that share one
// 32x32 multiplier under microcode. Flat mode divides lat and lon by 180 with rounding
// and sets a constant z. One item at a time: the next input is taken once the last result is in the output register.
// Reset (aresetn, synchronous, active low) clears control, the point counter and
// sets radius to 1.0 and sphere mode; no clearing pass.
module latlon_to_cartesian_vertex_unit #(
    parameter int unsigned MAX_POINTS = lvc_pkg::MAX_POINTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // latitude[23:0], longitude[48:24], shape_start[49], zero pad
    input  logic [lvc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // coord_x[24:0], coord_y[49:25], coord_z[74:50], triangle_valid[75],
    // triangle_first[91:76], zero pad
    output logic [lvc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lvc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [lvc_pkg::RAD_W-1:0]      cfg_data
);

    localparam logic [lvc_pkg::CNT_W-1:0] CAP =
        (MAX_POINTS - 1 > 65535) ? 16'hFFFF : 16'(MAX_POINTS - 1);

    logic [lvc_pkg::RAD_W-1:0] radius_reg;
    logic                      mode_reg;
    logic [lvc_pkg::CNT_W-1:0] count_reg, count_next;

    logic signed [lvc_pkg::LAT_W-1:0] lat_reg;
    logic signed [lvc_pkg::LON_W-1:0] lon_reg;
    logic                             tri_valid_reg, tri_valid_next;
    logic [lvc_pkg::CNT_W-1:0]        tri_first_reg, tri_first_next;

    logic                      out_valid_reg;
    lvc_pkg::coord_t           out_x_reg, out_y_reg, out_z_reg;
    logic                      out_tv_reg;
    logic [lvc_pkg::CNT_W-1:0] out_tf_reg;

    logic [lvc_pkg::CNT_W-1:0] idx;
    logic                      in_fire, out_free, seq_ready, out_load;
    lvc_pkg::seq_ctl_t         ctl;
    lvc_pkg::issue_t           iss;
    lvc_pkg::wb_t              wb;
    lvc_pkg::coord_t           cx, cy, cz;

    assign s_tready  = seq_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // point index of this transaction and the strip triangle it closes
    always_comb begin
        idx = s_tdata[49] ? '0 : count_reg;
        if (idx > CAP) begin
            idx = CAP;
        end
        count_next     = (idx < CAP) ? idx + 1'b1 : CAP;
        tri_valid_next = (idx >= 16'd2);
        tri_first_next = tri_valid_next ? idx - 16'd2 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= lvc_pkg::RADIUS_RESET;
            mode_reg      <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lvc_pkg::REG_RADIUS) begin
                    radius_reg <= cfg_data;
                end else if (cfg_index == lvc_pkg::REG_MODE) begin
                    mode_reg <= cfg_data[0];
                end
            end
            if (in_fire) begin
                count_reg <= count_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            lat_reg       <= s_tdata[23:0];
            lon_reg       <= s_tdata[48:24];
            tri_valid_reg <= tri_valid_next;
            tri_first_reg <= tri_first_next;
        end
        if (out_load) begin
            out_x_reg  <= cx;
            out_y_reg  <= cy;
            out_z_reg  <= cz;
            out_tv_reg <= tri_valid_reg;
            out_tf_reg <= tri_first_reg;
        end
    end

    lvc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_fire),
        .mode     (mode_reg),
        .out_free (out_free),
        .ctl      (ctl),
        .ready    (seq_ready),
        .load     (out_load)
    );

    lvc_regfile u_regfile (
        .aclk    (aclk),
        .lat     (lat_reg),
        .lon     (lon_reg),
        .radius  (radius_reg),
        .ctl     (ctl),
        .wb      (wb),
        .iss     (iss),
        .coord_x (cx),
        .coord_y (cy),
        .coord_z (cz)
    );

    lvc_mul_unit u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .iss     (iss),
        .wb      (wb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_tf_reg, out_tv_reg, out_z_reg, out_y_reg, out_x_reg};

    // one item at a time: the input closes right after a transaction
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("point counter beyond its cap");

    // the multiplier pipe is empty when a result is handed to the output
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !wb.valid)
        else $error("result loaded with a writeback still pending");

endmodule

// ===== tb/latlon_to_cartesian_vertex_unit_test.sv =====
// testbench for latlon_to_cartesian_vertex_unit: stream points in, compare vertices out
// needs rtl/lvc_pkg.sv and rtl/latlon_to_cartesian_vertex_unit.sv with its submodules; predicts every vertex
// in fixed point and checks each result transaction in order
module latlon_to_cartesian_vertex_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 60;
    localparam int HOLD_CYCLES    = 600;
    localparam int MAX_GAP        = 40;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int LONG_SHAPE     = 70;
    localparam int REPORT_LINES   = 40;

    localparam logic [lvc_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lvc_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // angles in Q16 degrees
    localparam int DEG45  = 2949120;
    localparam int DEG90  = 5898240;
    localparam int DEG180 = 11796480;
    localparam longint DEG360    = 64'sd23592960;
    localparam longint RAD_Q30   = 64'sd18740330;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint COORD_MAX = 64'sd16777215;
    localparam longint FLAT_Z_Q16 = -64'sd131;
    localparam int FLAT_DIVISOR  = 180;
    localparam int ONE_Q16       = 65536;

    localparam logic [23:0] LAT_MIN_BITS = 24'h800000;
    localparam logic [23:0] LAT_MAX_BITS = 24'h7FFFFF;
    localparam logic [24:0] LON_MIN_BITS = 25'h1000000;
    localparam logic [24:0] LON_MAX_BITS = 25'h0FFFFFF;

    localparam int unsigned VERTEX_CAP =
        (lvc_pkg::MAX_POINTS - 1 > 65535) ? 65535 : lvc_pkg::MAX_POINTS - 1;

    typedef struct packed {
        logic [24:0] x;
        logic [24:0] y;
        logic [24:0] z;
        logic        tri_valid;
        logic [15:0] tri_first;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [lvc_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lvc_pkg::M_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lvc_pkg::IDX_W-1:0] cfg_index = '0;
    logic [lvc_pkg::RAD_W-1:0] cfg_data = '0;

    // predictor state, mirrors the block's registers and point counter
    logic [23:0] radius_q = 24'd65536;
    logic sphere_mode = 1'b1;
    int unsigned next_index = 0;

    vertex_t expected_vertices[$];
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    latlon_to_cartesian_vertex_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic longint mul_round(input longint a, input longint b, input int sh);
        longint p, half;
        p = a * b;
        half = longint'(1) << (sh - 1);
        if (p >= 0) return (p + half) >>> sh;
        return -((-p + half) >>> sh);
    endfunction

    function automatic longint div_round(input longint a, input longint d);
        if (a >= 0) return (a + d / 2) / d;
        return -((-a + d / 2) / d);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < -COORD_MAX) return -COORD_MAX;
        return v;
    endfunction

    // sine and cosine in Q30 of an angle in Q16 degrees, series on a +-45 degree residual
    task automatic sincos_q30(input longint ang, output longint sn, output longint cs);
        longint r, q, d, t, t2, s, c;
        r = ang % DEG360;
        if (r < 0) r += DEG360;
        q = (r + DEG45) / DEG90;
        d = r - q * DEG90;
        t = mul_round(d, RAD_Q30, 16);
        t2 = mul_round(t, t, 30);
        s = ONE_Q30 - t2 / 42;
        s = ONE_Q30 - mul_round(t2, s, 30) / 20;
        s = ONE_Q30 - mul_round(t2, s, 30) / 6;
        s = mul_round(t, s, 30);
        c = ONE_Q30 - t2 / 56;
        c = ONE_Q30 - mul_round(t2, c, 30) / 30;
        c = ONE_Q30 - mul_round(t2, c, 30) / 12;
        c = ONE_Q30 - mul_round(t2, c, 30) / 2;
        case (q[1:0])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    task automatic predict_vertex(input logic [23:0] lat_bits, input logic [24:0] lon_bits,
                                  input logic start);
        longint lat, lon, sla, cla, slo, clo, x, y, z;
        int unsigned idx;
        vertex_t v;
        lat = $signed(lat_bits);
        lon = $signed(lon_bits);
        if (sphere_mode) begin
            sincos_q30(lat, sla, cla);
            sincos_q30(lon, slo, clo);
            x = mul_round(mul_round(cla, clo, 30), radius_q, 30);
            y = mul_round(mul_round(cla, slo, 30), radius_q, 30);
            z = mul_round(sla, radius_q, 30);
        end else begin
            x = div_round(lat, FLAT_DIVISOR);
            y = div_round(lon, FLAT_DIVISOR);
            z = FLAT_Z_Q16;
        end
        x = clamp_coord(x);
        y = clamp_coord(y);
        z = clamp_coord(z);
        idx = start ? 0 : next_index;
        if (idx > VERTEX_CAP) idx = VERTEX_CAP;
        next_index = (idx < VERTEX_CAP) ? idx + 1 : VERTEX_CAP;
        v.x = x[24:0];
        v.y = y[24:0];
        v.z = z[24:0];
        v.tri_valid = (idx >= 2);
        v.tri_first = (idx >= 2) ? 16'(idx - 2) : 16'd0;
        expected_vertices.insert(expected_vertices.size(), v);
    endtask

    // ---------------- driving ----------------

    task automatic send_point(input logic [23:0] lat, input logic [24:0] lon,
                              input logic start);
        int gap;
        gap = 0;
        while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {start, lon, lat};
        do @(posedge aclk); while (!s_tready);
        predict_vertex(lat, lon, start);
    endtask

    task automatic write_register(input logic [lvc_pkg::IDX_W-1:0] index,
                                  input logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            lvc_pkg::REG_RADIUS: radius_q = value;
            lvc_pkg::REG_MODE:   sphere_mode = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [23:0] random_latitude();
        int k;
        k = $urandom_range(4);
        case ($urandom_range(9))
            7, 8: return 24'($urandom());
            9: return 24'((k - 2) * DEG45 + int'($urandom_range(2)) - 1);
            default: return 24'(int'($urandom_range(2 * DEG90)) - DEG90);
        endcase
    endfunction

    function automatic logic [24:0] random_longitude();
        int k;
        k = $urandom_range(8);
        case ($urandom_range(9))
            7, 8: return 25'($urandom());
            9: return 25'((k - 4) * DEG45 + int'($urandom_range(2)) - 1);
            default: return 25'(int'($urandom_range(2 * DEG180)) - DEG180);
        endcase
    endfunction

    function automatic logic [23:0] random_radius();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'(ONE_Q16);
            3: return 24'($urandom());
            default: return 24'($urandom_range(1 << 20));
        endcase
    endfunction

    // ---------------- receiving and checking ----------------

    always @(negedge aclk) begin : drive_ready
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : check_results
        vertex_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[24:0];
            got.y = m_tdata[49:25];
            got.z = m_tdata[74:50];
            got.tri_valid = m_tdata[75];
            got.tri_first = m_tdata[91:76];
            if (expected_vertices.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_vertices.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("coord_x got %0d want %0d",
                                              $signed(got.x), $signed(want.x)));
                if (got.y !== want.y)
                    report_mismatch($sformatf("coord_y got %0d want %0d",
                                              $signed(got.y), $signed(want.y)));
                if (got.z !== want.z)
                    report_mismatch($sformatf("coord_z got %0d want %0d",
                                              $signed(got.z), $signed(want.z)));
                if (got.tri_valid !== want.tri_valid)
                    report_mismatch($sformatf("triangle_valid got %b want %b",
                                              got.tri_valid, want.tri_valid));
                if (got.tri_first !== want.tri_first)
                    report_mismatch($sformatf("triangle_first got %0d want %0d",
                                              got.tri_first, want.tri_first));
            end
        end
    end

    // a stretch with no transaction on any channel means the block hung
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // registers untouched since reset: unit radius, sphere mode
    task automatic test_reset_defaults();
        idle_pct = 0;
        stall_pct = 0;
        send_point(24'd0, 25'd0, 1'b1);
        send_point(24'(DEG90), 25'd0, 1'b0);
        send_point(24'(-DEG90), 25'(DEG180), 1'b0);
        send_point(24'(DEG45), 25'(-DEG45), 1'b0);
        send_point(24'(-DEG45 - 1), 25'(3 * DEG45), 1'b0);
        // out-of-range angles wrap
        send_point(LAT_MAX_BITS, LON_MIN_BITS, 1'b0);
        send_point(LAT_MIN_BITS, LON_MAX_BITS, 1'b0);
        drain_results();
    endtask

    task automatic test_flat_projection();
        write_register(lvc_pkg::REG_MODE, 24'd0);
        send_point(24'(DEG90), 25'(DEG180), 1'b1);
        send_point(24'(-DEG90), 25'(-DEG180), 1'b0);
        // half-way rounding away from zero
        send_point(24'd90, 25'(-90), 1'b0);
        send_point(24'd89, 25'(-89), 1'b0);
        send_point(LAT_MIN_BITS, LON_MAX_BITS, 1'b0);
        send_point(LAT_MAX_BITS, LON_MIN_BITS, 1'b0);
        drain_results();
    endtask

    task automatic test_radius_extremes();
        write_register(lvc_pkg::REG_MODE, 24'd1);
        write_register(lvc_pkg::REG_RADIUS, 24'hFFFFFF);
        send_point(24'd0, 25'd0, 1'b1);
        send_point(24'(DEG90), 25'd0, 1'b0);
        send_point(24'(-DEG90), 25'(DEG90), 1'b0);
        drain_results();
        write_register(lvc_pkg::REG_RADIUS, 24'd0);
        send_point(24'(DEG45), 25'(DEG45), 1'b0);
        drain_results();
    endtask

    // writes above the last register index must leave radius and mode alone
    task automatic test_spare_register_index();
        write_register(lvc_pkg::REG_RADIUS, 24'(3 * ONE_Q16));
        write_register(REG_SPARE_2, 24'd0);
        write_register(REG_SPARE_3, 24'd0);
        send_point(24'(DEG45), 25'(-DEG90), 1'b1);
        send_point(24'(-DEG45), 25'(DEG45), 1'b0);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        write_register(lvc_pkg::REG_MODE, 24'd0);
        hold_request = HOLD_CYCLES;
        repeat (16) send_point(random_latitude(), random_longitude(), $urandom_range(3) == 0);
        drain_results();
        write_register(lvc_pkg::REG_MODE, 24'd1);
        write_register(lvc_pkg::REG_RADIUS, 24'(ONE_Q16));
        hold_request = HOLD_CYCLES;
        repeat (8) send_point(random_latitude(), random_longitude(), $urandom_range(3) == 0);
        // sender waits for the block to empty before going on
        drain_results();
        repeat (6) send_point(random_latitude(), random_longitude(), 1'b0);
        drain_results();
    endtask

    task automatic test_random_points(input int total);
        int per_batch;
        logic [23:0] mode;
        per_batch = total / 16;
        for (int stage = 0; stage < 4; stage++) begin
            case (stage)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            for (int batch = 0; batch < 4; batch++) begin
                mode = 24'((batch + stage) % 2);
                if ($urandom_range(1)) begin
                    write_register(lvc_pkg::REG_RADIUS, random_radius());
                    write_register(lvc_pkg::REG_MODE, mode);
                end else begin
                    write_register(lvc_pkg::REG_MODE, mode);
                    write_register(lvc_pkg::REG_RADIUS, random_radius());
                end
                repeat (per_batch)
                    send_point(random_latitude(), random_longitude(),
                               $urandom_range(99) < 12);
                drain_results();
            end
        end
    endtask

    // one long shape in flat mode keeps the strip index counting, then a restart
    task automatic test_long_shape();
        idle_pct = 0;
        stall_pct = 0;
        write_register(lvc_pkg::REG_MODE, 24'd0);
        for (int n = 0; n < LONG_SHAPE; n++)
            send_point(random_latitude(), random_longitude(), n == 0);
        send_point(random_latitude(), random_longitude(), 1'b1);
        repeat (3) send_point(random_latitude(), random_longitude(), 1'b0);
        drain_results();
    endtask

    initial begin : run_tests
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_flat_projection();
        test_radius_extremes();
        test_spare_register_index();
        test_output_backpressure();
        test_random_points(RANDOM_ITEMS);
        test_long_shape();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_vertices.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lvc_pkg.sv
rtl/lvc_mul_unit.sv
rtl/lvc_regfile.sv
rtl/lvc_seq.sv
rtl/latlon_to_cartesian_vertex_unit.sv
tb/latlon_to_cartesian_vertex_unit_test.sv
